>>> rtl/decimal_text_to_q16_16_top_assert.svh
// Assertion macros for the decimal text parser
`ifndef DECIMAL_TEXT_TO_Q16_16_TOP_ASSERT_SVH
`define DECIMAL_TEXT_TO_Q16_16_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define DTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

	// widest fields over the parameter ranges (up to nine fraction digits, limit 32767)
	localparam int INT_MAX_W = 15;
	localparam int FD_MAX_W  = 30;
	localparam int CNT_MAX_W = 4;
	localparam int Q_W       = 17;
	localparam int NUM_W     = FD_MAX_W + 16 + 1;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [32:0] MAG_MAX = 33'h0_7FFF_FFFF;

	typedef struct packed {
		logic                 neg;
		logic                 ok;
		logic [INT_MAX_W-1:0] int_part;
		logic [FD_MAX_W-1:0]  frac_digits;
		logic [CNT_MAX_W-1:0] frac_count;
	} rec_t;

	function automatic logic [FD_MAX_W-1:0] pow10(input logic [CNT_MAX_W-1:0] k);
		logic [FD_MAX_W-1:0] r;
		begin
			case (k)
				4'd0: r = 30'd1;
				4'd1: r = 30'd10;
				4'd2: r = 30'd100;
				4'd3: r = 30'd1000;
				4'd4: r = 30'd10000;
				4'd5: r = 30'd100000;
				4'd6: r = 30'd1000000;
				4'd7: r = 30'd10000000;
				4'd8: r = 30'd100000000;
				4'd9: r = 30'd1000000000;
				default: r = 30'd1;
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

>>> rtl/dtq_front.sv
`default_nettype none

module dtq_front #(
	parameter int FRACTION_DIGITS_KEPT = 7,
	parameter int INTEGER_LIMIT        = 32767
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        char_valid,
	output logic             char_stall,
	input  wire logic        char_present,
	input  wire logic [7:0]  char_code,
	input  wire logic        last_char,
	input  wire logic        q_full,
	output logic             push,
	output dtq_pkg::rec_t    push_data
);

	localparam int IW   = $clog2(INTEGER_LIMIT + 1);
	localparam int IP_W = IW + 4;
	localparam int FD_W = $clog2(10 ** FRACTION_DIGITS_KEPT);
	localparam int FP_W = FD_W + 4;
	localparam int CW   = $clog2(FRACTION_DIGITS_KEPT + 1);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_INT   = 2'd1;
	localparam logic [1:0] PH_FRAC  = 2'd2;

	logic [1:0]      phase_q, phase_n;
	logic            neg_q, neg_n;
	logic [IW-1:0]   int_q, int_n;
	logic [FD_W-1:0] fd_q, fd_n;
	logic [CW-1:0]   cnt_q, cnt_n;
	logic            saw_q, saw_n;
	logic            fail_q, fail_n;

	logic            accept;
	logic            is_digit;
	logic [3:0]      dval;
	logic [IP_W-1:0] int_prod;
	logic [FP_W-1:0] fd_prod;

	assign char_stall = q_full;
	assign accept     = char_valid && !q_full;
	assign push       = accept && last_char;

	always_comb begin
		is_digit = char_code inside {[dtq_pkg::CH_ZERO:dtq_pkg::CH_NINE]};
		dval     = char_code[3:0];
		int_prod = IP_W'({int_q, 3'b000}) + IP_W'({int_q, 1'b0}) + IP_W'(dval);
		fd_prod  = FP_W'({fd_q, 3'b000}) + FP_W'({fd_q, 1'b0}) + FP_W'(dval);

		phase_n = phase_q;
		neg_n   = neg_q;
		int_n   = int_q;
		fd_n    = fd_q;
		cnt_n   = cnt_q;
		saw_n   = saw_q;
		fail_n  = fail_q;

		if (char_present && !fail_q) begin
			if (char_code == dtq_pkg::CH_MINUS && phase_q == PH_START) begin
				neg_n   = 1'b1;
				phase_n = PH_INT;
			end else if (is_digit && phase_q != PH_FRAC) begin
				phase_n = PH_INT;
				if (int_prod > IP_W'(INTEGER_LIMIT)) begin
					fail_n = 1'b1;
				end else begin
					int_n = int_prod[IW-1:0];
					saw_n = 1'b1;
				end
			end else if (char_code == dtq_pkg::CH_POINT && phase_q != PH_FRAC) begin
				phase_n = PH_FRAC;
			end else if (is_digit && phase_q == PH_FRAC) begin
				// digits past the kept count are swallowed
				if (cnt_q < CW'(FRACTION_DIGITS_KEPT)) begin
					fd_n  = fd_prod[FD_W-1:0];
					cnt_n = cnt_q + CW'(1);
					saw_n = 1'b1;
				end
			end else begin
				fail_n = 1'b1;
			end
		end

		push_data.neg         = neg_n;
		push_data.ok          = !fail_n && saw_n;
		push_data.int_part    = dtq_pkg::INT_MAX_W'(int_n);
		push_data.frac_digits = dtq_pkg::FD_MAX_W'(fd_n);
		push_data.frac_count  = dtq_pkg::CNT_MAX_W'(cnt_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			int_q   <= '0;
			fd_q    <= '0;
			cnt_q   <= '0;
			saw_q   <= 1'b0;
			fail_q  <= 1'b0;
		end else if (accept) begin
			if (last_char) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				int_q   <= '0;
				fd_q    <= '0;
				cnt_q   <= '0;
				saw_q   <= 1'b0;
				fail_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				int_q   <= int_n;
				fd_q    <= fd_n;
				cnt_q   <= cnt_n;
				saw_q   <= saw_n;
				fail_q  <= fail_n;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/dtq_queue.sv
`default_nettype none

module dtq_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dtq_pkg::rec_t push_data,
	input  wire logic          pop,
	output dtq_pkg::rec_t      pop_data,
	output logic [1:0]         level,
	output logic               full
);

	dtq_pkg::rec_t entry_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    level_q;

	assign level    = level_q;
	assign full     = level_q == 2'd2;
	assign pop_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   level_q <= level_q + 2'd1;
				2'b01:   level_q <= level_q - 2'd1;
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/dtq_back.sv
`default_nettype none

module dtq_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire dtq_pkg::rec_t head,
	input  wire logic [1:0]   q_level,
	output logic              pop,
	output logic              result_valid,
	input  wire logic         result_stall,
	output logic signed [31:0] fixed_value,
	output logic              parse_ok
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	localparam int FW = dtq_pkg::FD_MAX_W;
	localparam int QW = dtq_pkg::Q_W;
	localparam int SW = $clog2(QW);

	logic [1:0]                     state_q;
	logic                           neg_q;
	logic                           ok_q;
	logic [dtq_pkg::INT_MAX_W-1:0]  int_q;
	logic [FW-1:0]                  scale_q;
	logic [FW-1:0]                  rem_q;
	logic [QW-1:0]                  sh_q;
	logic [SW-1:0]                  step_q;
	logic                           res_valid_q;
	logic signed [31:0]             res_value_q;
	logic                           res_ok_q;

	logic [FW-1:0]                  head_scale;
	logic [dtq_pkg::NUM_W-1:0]      numer;
	logic [FW:0]                    trial;
	logic                           ge;
	logic [32:0]                    mag;
	logic                           fin_go;
	logic                           fin_ok;

	assign pop          = state_q == ST_IDLE && q_level != 2'd0;
	assign fin_go       = state_q == ST_FIN && (!res_valid_q || !result_stall);
	assign result_valid = res_valid_q;
	assign fixed_value  = res_value_q;
	assign parse_ok     = res_ok_q;

	always_comb begin
		// rounding: digits * 2^16 + scale/2, then divide by scale
		head_scale = dtq_pkg::pow10(head.frac_count);
		numer = {1'b0, head.frac_digits, 16'd0} + dtq_pkg::NUM_W'(head_scale >> 1);
		trial = {rem_q, sh_q[QW-1]};
		ge    = trial >= {1'b0, scale_q};
		mag   = {2'b00, int_q, 16'd0} + 33'(sh_q);
		fin_ok = ok_q && (mag <= dtq_pkg::MAG_MAX);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			neg_q   <= head.neg;
			ok_q    <= head.ok;
			int_q   <= head.int_part;
			scale_q <= head_scale;
			rem_q   <= numer[dtq_pkg::NUM_W-1:QW];
			sh_q    <= numer[QW-1:0];
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? FW'(trial - {1'b0, scale_q}) : trial[FW-1:0];
			sh_q  <= {sh_q[QW-2:0], ge};
		end
		if (fin_go) begin
			res_ok_q    <= fin_ok;
			res_value_q <= !fin_ok ? 32'sd0 :
				(neg_q ? -$signed(mag[31:0]) : $signed(mag[31:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(QW - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (fin_go) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/decimal_text_to_q16_16_top.sv
// Characters: one transaction per cycle while char_stall is low, no gaps within a string.
// Result: the string is loaded from the queue, runs a 17-step restoring divider for the
// rounded fraction; a finishing state writes the output register, held by result_stall.
// A two-entry queue holds finished strings, so parsing can go on while the divider runs.
// Reset (arst_n low, asynchronous): parser at start of string, queue empty, no result pending.
`default_nettype none
`include "decimal_text_to_q16_16_top_assert.svh"

module decimal_text_to_q16_16_top #(
	parameter int FRACTION_DIGITS_KEPT = 7,
	parameter int INTEGER_LIMIT        = 32767
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          char_valid,
	output logic               char_stall,
	input  wire logic          char_present,
	input  wire logic [7:0]    char_code,
	input  wire logic          last_char,
	output logic               result_valid,
	input  wire logic          result_stall,
	output logic signed [31:0] fixed_value,
	output logic               parse_ok
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic [1:0]    q_level;
	dtq_pkg::rec_t push_data;
	dtq_pkg::rec_t head;

	dtq_front #(
		.FRACTION_DIGITS_KEPT(FRACTION_DIGITS_KEPT),
		.INTEGER_LIMIT(INTEGER_LIMIT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_present(char_present),
		.char_code(char_code),
		.last_char(last_char),
		.q_full(q_full),
		.push(push),
		.push_data(push_data)
	);

	dtq_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.pop_data(head),
		.level(q_level),
		.full(q_full)
	);

	dtq_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_level(q_level),
		.pop(pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.fixed_value(fixed_value),
		.parse_ok(parse_ok)
	);

	// a failed parse always reports zero
	`DTQ_ASSERT_IMP(a_fail_zero, clk, arst_n, result_valid && !parse_ok, fixed_value == 32'sd0)
	// a magnitude above 2^31-1 fails the parse, so the most negative code never appears
	`DTQ_ASSERT_IMP(a_no_min, clk, arst_n, result_valid, fixed_value != 32'sh8000_0000)
	// an accepted last character always lands in the queue
	`DTQ_ASSERT_NXT(a_push_lands, clk, arst_n, char_valid && !char_stall && last_char,
		q_level != 2'd0)

endmodule

`default_nettype wire
